### hw/rtl/task_table_round_robin_scheduler_assert.svh
// Assertion macros for the task scheduler checker
`ifndef TASK_TABLE_ROUND_ROBIN_SCHEDULER_ASSERT_SVH
`define TASK_TABLE_ROUND_ROBIN_SCHEDULER_ASSERT_SVH
// assert that a implies b in the same cycle
`define TTS_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("check failed");
// assert that a implies b in the next cycle
`define TTS_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("check failed");
`endif

### hw/rtl/tts_pkg.sv
// ----------------------------------------------------------------------
// tts_pkg: shared parameters and codes of the task scheduler
// Command, status and slot state codes.
// ----------------------------------------------------------------------
package tts_pkg;
  localparam int DEF_NUM_SLOTS = 16;

  localparam logic [2:0] CMD_SPAWN    = 3'd0;
  localparam logic [2:0] CMD_SCHEDULE = 3'd1;
  localparam logic [2:0] CMD_YIELD    = 3'd2;
  localparam logic [2:0] CMD_SLEEP    = 3'd3;
  localparam logic [2:0] CMD_WAKEUP   = 3'd4;
  localparam logic [2:0] CMD_EXIT     = 3'd5;
  localparam logic [2:0] CMD_WAIT     = 3'd6;
  localparam logic [2:0] CMD_NOP      = 3'd7;

  localparam logic [2:0] STS_OK       = 3'd0;
  localparam logic [2:0] STS_NO_CUR   = 3'd1;
  localparam logic [2:0] STS_FULL     = 3'd2;
  localparam logic [2:0] STS_IDLE     = 3'd3;
  localparam logic [2:0] STS_NO_KIDS  = 3'd4;
  localparam logic [2:0] STS_ASLEEP   = 3'd5;

  localparam logic [2:0] ST_UNUSED    = 3'd0;
  localparam logic [2:0] ST_SLEEPING  = 3'd2;
  localparam logic [2:0] ST_RUNNABLE  = 3'd3;
  localparam logic [2:0] ST_RUNNING   = 3'd4;
  localparam logic [2:0] ST_ZOMBIE    = 3'd5;
endpackage

### hw/rtl/tts_if.sv
// ----------------------------------------------------------------------
// tts_cmd_if / tts_res_if: command and result channels
// Valid/ready channels carrying one command or one result beat.
// ----------------------------------------------------------------------
interface tts_cmd_if;
  logic               valid;
  logic               ready;
  logic [2:0]         cmd;
  logic               has_parent;
  logic [15:0]        channel;
  logic signed [31:0] exit_code;
  modport source (output valid, cmd, has_parent, channel, exit_code, input ready);
  modport sink (input valid, cmd, has_parent, channel, exit_code, output ready);
endinterface

interface tts_res_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [15:0]        task_id;
  logic [3:0]         slot_index;
  logic signed [31:0] collected_code;
  logic [4:0]         woken_count;
  modport source (output valid, status, task_id, slot_index, collected_code,
                  woken_count, input ready);
  modport sink (input valid, status, task_id, slot_index, collected_code,
                woken_count, output ready);
endinterface

### hw/rtl/task_table_round_robin_scheduler.sv
// ----------------------------------------------------------------------
// task_table_round_robin_scheduler: task table with round-robin pick
// Slot table walked one slot per cycle by a small sequencer.
// ----------------------------------------------------------------------
//  channel | dir | beat
//  cmd     | in  | cmd, has_parent, channel, exit_code
//  res     | out | status, task_id, slot_index, collected_code, woken_count
//
// Each pass over the table visits one slot per cycle through the
// shared slot compare unit. Exit runs a child pass, a wake pass for
// init if needed, and a parent wake pass if the task has a parent.
// Reset clears the table at once. cmd.ready is low while a command
// runs or its result waits; the result holds until taken.
module task_table_round_robin_scheduler
  import tts_pkg::*;
#(
  parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
  input logic clk,
  input logic rst,
  tts_cmd_if.sink   cmd,
  tts_res_if.source res
);
  localparam int SW = $clog2(NUM_SLOTS);
  localparam int PW = SW + 1;
  localparam logic [PW-1:0] NO_SLOT = PW'(NUM_SLOTS);
  localparam logic [SW-1:0] LAST = SW'(NUM_SLOTS - 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_CHILD = 6'b000100,
    S_WINIT = 6'b001000,
    S_WPAR  = 6'b010000,
    S_OUT   = 6'b100000
  } fsm_t;

  fsm_t state;
  logic [2:0]  slot_state   [NUM_SLOTS];
  logic [15:0] slot_id      [NUM_SLOTS];
  logic [PW-1:0] slot_parent [NUM_SLOTS];
  logic [15:0] slot_channel [NUM_SLOTS];
  logic [31:0] slot_code    [NUM_SLOTS];
  logic [PW-1:0] current_slot, init_slot;
  logic [SW-1:0] scan_start;
  logic [15:0] next_id;

  logic [2:0]  op;
  logic        op_par;
  logic [15:0] op_chan;
  logic [31:0] op_code;
  logic [SW-1:0] idx;
  logic [SW:0]   cnt;
  logic        zkid, kids;
  logic [2:0]  r_status;
  logic [15:0] r_id;
  logic [SW-1:0] r_slot;
  logic [31:0] r_code;
  logic [4:0]  r_woken;

  logic [SW-1:0] cur;
  logic have_cur;
  assign have_cur = current_slot < NO_SLOT;
  assign cur = current_slot[SW-1:0];

  // shared slot compare unit
  logic [2:0] s_st;
  logic s_mine, s_sleep_on;
  logic [15:0] wake_ch;
  assign s_st = slot_state[idx];
  assign s_mine = (s_st != ST_UNUSED) && (slot_parent[idx] == current_slot);
  assign wake_ch = (state == S_WINIT) ? 16'(init_slot)
                 : (state == S_WPAR) ? 16'(slot_parent[cur]) : op_chan;
  assign s_sleep_on = (s_st == ST_SLEEPING) && (slot_channel[idx] == wake_ch);

  logic pass_done;
  assign pass_done = (idx == LAST);

  assign cmd.ready = (state == S_IDLE);
  assign res.valid = (state == S_OUT);
  assign res.status = r_status;
  assign res.task_id = r_id;
  assign res.slot_index = 4'(r_slot);
  assign res.collected_code = r_code;
  assign res.woken_count = r_woken;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      current_slot <= NO_SLOT;
      init_slot <= NO_SLOT;
      scan_start <= '0;
      next_id <= 16'd1;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_state[i] <= ST_UNUSED;
        slot_id[i] <= '0;
        slot_parent[i] <= NO_SLOT;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            op <= cmd.cmd;
            op_par <= cmd.has_parent;
            op_chan <= cmd.channel;
            op_code <= cmd.exit_code;
            r_status <= STS_OK;
            r_id <= '0;
            r_slot <= '0;
            r_code <= '0;
            r_woken <= '0;
            zkid <= 1'b0;
            kids <= 1'b0;
            cnt <= '0;
            idx <= (cmd.cmd == CMD_SCHEDULE) ? scan_start : '0;
            priority if (cmd.cmd == CMD_SCHEDULE && have_cur) begin
              r_id <= slot_id[cur];
              r_slot <= cur;
              state <= S_OUT;
            end else if (cmd.cmd == CMD_SPAWN && cmd.has_parent && !have_cur) begin
              r_status <= STS_NO_CUR;
              state <= S_OUT;
            end else if (cmd.cmd == CMD_SPAWN || cmd.cmd == CMD_SCHEDULE
                         || cmd.cmd == CMD_WAKEUP) begin
              state <= S_SCAN;
            end else if (cmd.cmd == CMD_NOP) begin
              state <= S_OUT;
            end else if (!have_cur) begin
              r_status <= STS_NO_CUR;
              state <= S_OUT;
            end else if (cmd.cmd == CMD_YIELD) begin
              slot_state[cur] <= ST_RUNNABLE;
              current_slot <= NO_SLOT;
              state <= S_OUT;
            end else if (cmd.cmd == CMD_SLEEP) begin
              slot_channel[cur] <= cmd.channel;
              slot_state[cur] <= ST_SLEEPING;
              current_slot <= NO_SLOT;
              state <= S_OUT;
            end else if (cmd.cmd == CMD_EXIT) begin
              state <= S_CHILD;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // one slot per cycle; spawn, schedule, wakeup and wait share this pass
          unique case (op)
            CMD_SPAWN: begin
              if (s_st == ST_UNUSED) begin
                slot_state[idx] <= ST_RUNNABLE;
                slot_id[idx] <= next_id;
                slot_channel[idx] <= '0;
                slot_code[idx] <= '0;
                slot_parent[idx] <= op_par ? current_slot : NO_SLOT;
                if (!op_par && init_slot == NO_SLOT) init_slot <= PW'(idx);
                next_id <= (next_id == 16'hFFFF) ? 16'd1 : next_id + 16'd1;
                r_id <= next_id;
                r_slot <= idx;
                state <= S_OUT;
              end else if (pass_done) begin
                r_status <= STS_FULL;
                state <= S_OUT;
              end
              idx <= idx + 1'b1;
            end
            CMD_SCHEDULE: begin
              if (s_st == ST_RUNNABLE) begin
                slot_state[idx] <= ST_RUNNING;
                current_slot <= PW'(idx);
                scan_start <= (idx == LAST) ? '0 : idx + 1'b1;
                r_id <= slot_id[idx];
                r_slot <= idx;
                state <= S_OUT;
              end else if (cnt == (SW+1)'(NUM_SLOTS - 1)) begin
                r_status <= STS_IDLE;
                state <= S_OUT;
              end
              idx <= (idx == LAST) ? '0 : idx + 1'b1;
              cnt <= cnt + 1'b1;
            end
            CMD_WAKEUP: begin
              if (s_sleep_on) begin
                slot_state[idx] <= ST_RUNNABLE;
                r_woken <= r_woken + 5'd1;
              end
              if (pass_done) state <= S_OUT;
              idx <= idx + 1'b1;
            end
            default: begin
              // wait: first zombie child, else note any child
              if (s_mine && s_st == ST_ZOMBIE) begin
                r_id <= slot_id[idx];
                r_slot <= idx;
                r_code <= slot_code[idx];
                slot_state[idx] <= ST_UNUSED;
                slot_id[idx] <= '0;
                slot_parent[idx] <= NO_SLOT;
                state <= S_OUT;
              end else if (pass_done) begin
                if (!(kids || s_mine)) begin
                  r_status <= STS_NO_KIDS;
                end else begin
                  slot_channel[cur] <= 16'(cur);
                  slot_state[cur] <= ST_SLEEPING;
                  current_slot <= NO_SLOT;
                  r_status <= STS_ASLEEP;
                end
                state <= S_OUT;
              end
              if (s_mine) kids <= 1'b1;
              idx <= idx + 1'b1;
            end
          endcase
        end
        S_CHILD: begin
          // hand children to init
          if (s_mine) begin
            slot_parent[idx] <= init_slot;
            if (init_slot != NO_SLOT && s_st == ST_ZOMBIE) zkid <= 1'b1;
          end
          idx <= pass_done ? '0 : idx + 1'b1;
          if (pass_done) begin
            if (zkid || (s_mine && init_slot != NO_SLOT && s_st == ST_ZOMBIE)) begin
              state <= S_WINIT;
            end else begin
              slot_code[cur] <= op_code;
              slot_state[cur] <= ST_ZOMBIE;
              state <= (slot_parent[cur] != NO_SLOT) ? S_WPAR : S_OUT;
              if (slot_parent[cur] == NO_SLOT) current_slot <= NO_SLOT;
            end
          end
        end
        S_WINIT: begin
          // wake init once (later passes find no sleepers on it)
          if (s_sleep_on) begin
            slot_state[idx] <= ST_RUNNABLE;
            r_woken <= r_woken + 5'd1;
          end
          idx <= pass_done ? '0 : idx + 1'b1;
          if (pass_done) begin
            slot_code[cur] <= op_code;
            slot_state[cur] <= ST_ZOMBIE;
            state <= (slot_parent[cur] != NO_SLOT) ? S_WPAR : S_OUT;
            if (slot_parent[cur] == NO_SLOT) current_slot <= NO_SLOT;
          end
        end
        S_WPAR: begin
          if (s_sleep_on) begin
            slot_state[idx] <= ST_RUNNABLE;
            r_woken <= r_woken + 5'd1;
          end
          idx <= idx + 1'b1;
          if (pass_done) begin
            current_slot <= NO_SLOT;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (res.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### hw/rtl/tts_checker.sv
// ----------------------------------------------------------------------
// tts_checker: port-level checks of the task scheduler
// Watches command and result beats on the top level ports.
// ----------------------------------------------------------------------
`include "task_table_round_robin_scheduler_assert.svh"
module tts_checker
  import tts_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic cmd_valid,
  input logic cmd_ready,
  input logic res_valid,
  input logic res_ready,
  input logic [2:0] res_status,
  input logic [15:0] res_task_id,
  input logic [4:0] res_woken_count
);
  // no new command while a result waits
  `TTS_ASSERT_IMP(a_busy_out, res_valid, !cmd_ready)
  // a command beat starts work, so the next cycle is busy
  `TTS_ASSERT_NXT(a_busy_after, cmd_valid && cmd_ready, !cmd_ready)
  // failed outcomes carry no task id
  `TTS_ASSERT_IMP(a_fail_noid, res_valid && res_status != STS_OK, res_task_id == 16'd0)
  // a stalled result holds its status
  `TTS_ASSERT_NXT(a_hold, res_valid && !res_ready, $stable(res_status))
  // at most sixteen wakeups per command
  `TTS_ASSERT_IMP(a_woken, res_valid, res_woken_count <= 5'd16)
endmodule

bind task_table_round_robin_scheduler tts_checker u_tts_checker (
  .clk(clk), .rst(rst),
  .cmd_valid(cmd.valid), .cmd_ready(cmd.ready),
  .res_valid(res.valid), .res_ready(res.ready),
  .res_status(res.status), .res_task_id(res.task_id),
  .res_woken_count(res.woken_count)
);

### tb/tts_sched_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------
// tts_sched_checker: scoreboard for the task table scheduler
// Mirrors the slot table on every accepted command beat, queues the
// predicted result and compares each accepted result beat field by field.
// ----------------------------------------------------------------------
module tts_sched_checker
  import tts_pkg::*;
#(
  parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
  input  logic clk,
  input  logic rst,
  tts_cmd_if   cmd_ch,
  tts_res_if   res_ch,
  output int   pending,
  output int   fails
);
  localparam logic [4:0] NO_SLOT = 5'(NUM_SLOTS);

  typedef struct packed {
    logic [2:0]         status;
    logic [15:0]        task_id;
    logic [3:0]         slot_index;
    logic signed [31:0] collected_code;
    logic [4:0]         woken_count;
  } sched_res_t;

  // Mirrored task table
  logic [2:0]  tbl_state  [NUM_SLOTS];
  logic [15:0] tbl_id     [NUM_SLOTS];
  logic [4:0]  tbl_parent [NUM_SLOTS];
  logic [15:0] tbl_chan   [NUM_SLOTS];
  logic [31:0] tbl_code   [NUM_SLOTS];
  logic [4:0]  running;
  logic [4:0]  init_task;
  logic [3:0]  rr_start;
  logic [15:0] id_next;

  sched_res_t expected_results[$];

  assign pending = expected_results.size();

  function automatic logic [4:0] wake_sleepers(logic [15:0] ch);
    logic [4:0] n;
    n = 0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (tbl_state[i] == ST_SLEEPING && tbl_chan[i] == ch) begin
        tbl_state[i] = ST_RUNNABLE;
        n++;
      end
    end
    return n;
  endfunction

  function automatic void free_slot(int i);
    tbl_state[i]  = ST_UNUSED;
    tbl_id[i]     = '0;
    tbl_parent[i] = NO_SLOT;
    tbl_chan[i]   = '0;
    tbl_code[i]   = '0;
  endfunction

  task automatic clear_table();
    for (int i = 0; i < NUM_SLOTS; i++) free_slot(i);
    running   = NO_SLOT;
    init_task = NO_SLOT;
    rr_start  = '0;
    id_next   = 16'd1;
  endtask

  // Advance the mirrored table by one command and return its result
  function automatic sched_res_t predict_command(logic [2:0] op, logic hp,
                                                 logic [15:0] ch, logic [31:0] code);
    sched_res_t r;
    logic       have_cur, kids;
    logic [4:0] cur;
    int         f, z, i;
    r = '0;
    have_cur = running < NO_SLOT;
    cur = have_cur ? running : 5'd0;
    if (op == CMD_SPAWN) begin
      if (hp && !have_cur) r.status = STS_NO_CUR;
      else begin
        f = NUM_SLOTS;
        for (int k = 0; k < NUM_SLOTS; k++)
          if (f == NUM_SLOTS && tbl_state[k] == ST_UNUSED) f = k;
        if (f == NUM_SLOTS) r.status = STS_FULL;
        else begin
          tbl_state[f]  = ST_RUNNABLE;
          tbl_id[f]     = id_next;
          tbl_chan[f]   = '0;
          tbl_code[f]   = '0;
          tbl_parent[f] = hp ? cur : NO_SLOT;
          if (!hp && init_task >= NO_SLOT) init_task = 5'(f);
          id_next = (id_next == 16'hFFFF) ? 16'd1 : id_next + 16'd1;
          r.task_id    = tbl_id[f];
          r.slot_index = 4'(f);
        end
      end
    end else if (op == CMD_SCHEDULE) begin
      if (have_cur) begin
        r.task_id    = tbl_id[cur];
        r.slot_index = 4'(cur);
      end else begin
        r.status = STS_IDLE;
        for (int n = 0; n < NUM_SLOTS; n++) begin
          i = (rr_start + n) % NUM_SLOTS;
          if (r.status == STS_IDLE && tbl_state[i] == ST_RUNNABLE) begin
            tbl_state[i] = ST_RUNNING;
            running      = 5'(i);
            rr_start     = 4'((i + 1) % NUM_SLOTS);
            r.status     = STS_OK;
            r.task_id    = tbl_id[i];
            r.slot_index = 4'(i);
          end
        end
      end
    end else if (op inside {CMD_YIELD, CMD_SLEEP, CMD_EXIT, CMD_WAIT} && !have_cur) begin
      r.status = STS_NO_CUR;
    end else if (op == CMD_YIELD) begin
      tbl_state[cur] = ST_RUNNABLE;
      running = NO_SLOT;
    end else if (op == CMD_SLEEP) begin
      tbl_chan[cur]  = ch;
      tbl_state[cur] = ST_SLEEPING;
      running = NO_SLOT;
    end else if (op == CMD_WAKEUP) begin
      r.woken_count = wake_sleepers(ch);
    end else if (op == CMD_EXIT) begin
      // Reparent children to init, then turn into a zombie
      for (int k = 0; k < NUM_SLOTS; k++) begin
        if (tbl_state[k] != ST_UNUSED && tbl_parent[k] == cur) begin
          if (init_task < NO_SLOT) begin
            tbl_parent[k] = init_task;
            if (tbl_state[k] == ST_ZOMBIE)
              r.woken_count += wake_sleepers(16'(init_task));
          end else tbl_parent[k] = NO_SLOT;
        end
      end
      tbl_code[cur]  = code;
      tbl_state[cur] = ST_ZOMBIE;
      if (tbl_parent[cur] < NO_SLOT)
        r.woken_count += wake_sleepers(16'(tbl_parent[cur]));
      running = NO_SLOT;
    end else if (op == CMD_WAIT) begin
      kids = 1'b0;
      z = NUM_SLOTS;
      for (int k = 0; k < NUM_SLOTS; k++) begin
        if (z == NUM_SLOTS && tbl_state[k] != ST_UNUSED && tbl_parent[k] == cur) begin
          kids = 1'b1;
          if (tbl_state[k] == ST_ZOMBIE) z = k;
        end
      end
      if (!kids) r.status = STS_NO_KIDS;
      else if (z < NUM_SLOTS) begin
        r.task_id        = tbl_id[z];
        r.slot_index     = 4'(z);
        r.collected_code = tbl_code[z];
        free_slot(z);
      end else begin
        tbl_chan[cur]  = 16'(cur);
        tbl_state[cur] = ST_SLEEPING;
        running  = NO_SLOT;
        r.status = STS_ASLEEP;
      end
    end
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    fails++;
  endtask

  // Predict on command beats, compare on result beats
  always @(posedge clk) begin
    sched_res_t want;
    if (rst) begin
      fails = 0;
      clear_table();
      expected_results.delete();
    end else begin
      if (cmd_ch.valid && cmd_ch.ready)
        expected_results.push_back(predict_command(cmd_ch.cmd, cmd_ch.has_parent,
                                                   cmd_ch.channel, cmd_ch.exit_code));
      if (res_ch.valid && res_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("[%0t] result beat with nothing expected", $realtime);
          fails++;
        end else begin
          want = expected_results.pop_front();
          if (res_ch.status !== want.status) report("status", res_ch.status, want.status);
          if (res_ch.task_id !== want.task_id) report("task_id", res_ch.task_id, want.task_id);
          if (res_ch.slot_index !== want.slot_index)
            report("slot_index", res_ch.slot_index, want.slot_index);
          if (res_ch.collected_code !== want.collected_code)
            report("collected_code", res_ch.collected_code, want.collected_code);
          if (res_ch.woken_count !== want.woken_count)
            report("woken_count", res_ch.woken_count, want.woken_count);
        end
      end
    end
  end
endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------
// tb_top: stimulus for the task table scheduler
// Directed corner commands, then weighted random command streams sent
// in bursts against a stalling receiver; the checker gives the verdict.
// ----------------------------------------------------------------------
module tb_top;
  import tts_pkg::*;

  localparam int NUM_RANDOM = 1530;

  typedef struct packed {
    logic [2:0]  op;
    logic        hp;
    logic [15:0] ch;
    logic [31:0] code;
  } sched_cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   pending, fails;
  sched_cmd_t cmd_list[$];

  tts_cmd_if cmd_if();
  tts_res_if res_if();

  task_table_round_robin_scheduler dut (
    .clk(clk), .rst(rst), .cmd(cmd_if.sink), .res(res_if.source)
  );

  tts_sched_checker chk (
    .clk(clk), .rst(rst), .cmd_ch(cmd_if), .res_ch(res_if),
    .pending(pending), .fails(fails)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: stall pattern switches between four random modes; one long hold-off
  always @(posedge clk) begin
    int cyc, mode;
    if (rst) begin
      cyc = 0;
      mode = 0;
      res_if.ready <= 1'b0;
    end else begin
      cyc++;
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      if (cyc >= 4000 && cyc < 4600) res_if.ready <= 1'b0;
      else case (mode)
        0: res_if.ready <= 1'b1;
        1: res_if.ready <= $urandom_range(0, 1);
        2: res_if.ready <= ($urandom_range(0, 7) == 0);
        default: res_if.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  function automatic sched_cmd_t make_cmd(logic [2:0] op, logic hp,
                                          logic [15:0] ch, logic [31:0] code);
    sched_cmd_t c;
    c.op = op; c.hp = hp; c.ch = ch; c.code = code;
    return c;
  endfunction

  // Weighted random command; spawn_bias pushes the table toward full
  function automatic sched_cmd_t random_cmd(int spawn_bias);
    sched_cmd_t c;
    int w;
    w = $urandom_range(0, 99);
    if (w < 15 + spawn_bias)      c.op = CMD_SPAWN;
    else if (w < 45 + spawn_bias) c.op = CMD_SCHEDULE;
    else if (w < 53 + spawn_bias) c.op = CMD_YIELD;
    else if (w < 61 + spawn_bias) c.op = CMD_SLEEP;
    else if (w < 72 + spawn_bias) c.op = CMD_WAKEUP;
    else if (w < 85 + spawn_bias) c.op = CMD_EXIT;
    else if (w < 98)              c.op = CMD_WAIT;
    else                          c.op = CMD_NOP;
    c.hp = ($urandom_range(0, 9) < 7);
    c.ch = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 17)) : 16'($urandom);
    case ($urandom_range(0, 9))
      0: c.code = 32'h8000_0000;
      1: c.code = 32'h7FFF_FFFF;
      2: c.code = 32'hFFFF_FFFF;
      default: c.code = $urandom;
    endcase
    return c;
  endfunction

  task automatic send_list(bit drain_midway);
    int gap, burst, idx;
    burst = 0;
    idx = 0;
    while (cmd_list.size() > 0) begin
      // Drop valid for a random gap between bursts
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        if (drain_midway && idx == 60) begin
          cmd_if.valid <= 1'b0;
          do @(posedge clk); while (pending != 0);
        end else if (gap > 0) begin
          cmd_if.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      cmd_if.cmd        <= cmd_list[0].op;
      cmd_if.has_parent <= cmd_list[0].hp;
      cmd_if.channel    <= cmd_list[0].ch;
      cmd_if.exit_code  <= cmd_list[0].code;
      cmd_if.valid      <= 1'b1;
      void'(cmd_list.pop_front());
      do @(posedge clk); while (!cmd_if.ready);
      burst--;
      idx++;
    end
    cmd_if.valid <= 1'b0;
  endtask

  initial begin
    cmd_if.valid <= 1'b0;
    cmd_if.cmd <= CMD_SPAWN;
    cmd_if.has_parent <= 1'b0;
    cmd_if.channel <= '0;
    cmd_if.exit_code <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: commands with no task, idle, init, children, table full
    cmd_list.push_back(make_cmd(CMD_YIELD, 0, 0, 0));
    cmd_list.push_back(make_cmd(CMD_SLEEP, 0, 16'hFFFF, 0));
    cmd_list.push_back(make_cmd(CMD_EXIT, 0, 0, 32'h8000_0000));
    cmd_list.push_back(make_cmd(CMD_WAIT, 0, 0, 0));
    cmd_list.push_back(make_cmd(CMD_SPAWN, 1, 0, 0));
    cmd_list.push_back(make_cmd(CMD_SCHEDULE, 0, 0, 0));
    cmd_list.push_back(make_cmd(CMD_NOP, 1, 16'hFFFF, 32'hFFFF_FFFF));
    cmd_list.push_back(make_cmd(CMD_SPAWN, 0, 0, 0));
    cmd_list.push_back(make_cmd(CMD_SCHEDULE, 0, 0, 0));
    cmd_list.push_back(make_cmd(CMD_SCHEDULE, 0, 0, 0));
    cmd_list.push_back(make_cmd(CMD_WAIT, 0, 0, 0));
    cmd_list.push_back(make_cmd(CMD_SCHEDULE, 0, 0, 0));
    cmd_list.push_back(make_cmd(CMD_SPAWN, 1, 0, 0));
    cmd_list.push_back(make_cmd(CMD_WAIT, 0, 0, 0));
    cmd_list.push_back(make_cmd(CMD_SCHEDULE, 0, 0, 0));
    cmd_list.push_back(make_cmd(CMD_EXIT, 0, 0, 32'h7FFF_FFFF));
    cmd_list.push_back(make_cmd(CMD_SCHEDULE, 0, 0, 0));
    cmd_list.push_back(make_cmd(CMD_WAIT, 0, 0, 0));
    cmd_list.push_back(make_cmd(CMD_SLEEP, 0, 16'd5, 0));
    cmd_list.push_back(make_cmd(CMD_WAKEUP, 0, 16'd5, 0));
    for (int i = 0; i < 17; i++) cmd_list.push_back(make_cmd(CMD_SPAWN, 0, 0, 0));
    send_list(1'b0);

    // Random: a spawn-heavy stretch, then two balanced stretches, repeated
    for (int i = 0; i < NUM_RANDOM; i++)
      cmd_list.push_back(random_cmd(((i / 150) % 3 == 0) ? 10 : 0));
    send_list(1'b1);

    // Drain, then allow the slowest command to finish
    do @(posedge clk); while (pending != 0);
    repeat (300) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end
endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/tts_pkg.sv
hw/rtl/tts_if.sv
hw/rtl/task_table_round_robin_scheduler.sv
hw/rtl/tts_checker.sv
tb/tts_sched_checker.sv
tb/tb_top.sv
